/* hw/rtl/bfdh_pkg.sv */
// constants, types and helper functions shared across the bloom filter design
`default_nettype none

package bfdh_pkg;

  // store geometry
  localparam int MaxBits    = 65536;
  localparam int MaxProbes  = 16;
  localparam int WordBits   = 64;
  localparam int StoreWords = MaxBits / WordBits;
  localparam int AddrW      = $clog2(StoreWords);
  localparam int BitIdxW    = $clog2(WordBits);
  localparam int PosW       = $clog2(MaxBits);
  localparam int ModW       = PosW + 1;
  localparam int CntW       = $clog2(MaxProbes) + 1;
  localparam int HashW      = 64;

  // reduction unit: bits folded in per cycle
  localparam int RedBits    = 8;
  localparam int RedCycles  = HashW / RedBits;
  localparam int RedCntW    = $clog2(RedCycles);

  // configuration port
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 17;
  localparam logic [CfgIdxW-1:0] CfgBitCount  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgHashCount = 1'd1;
  localparam logic [ModW-1:0]    BitCountRst  = ModW'(MaxBits);
  localparam logic [CntW-1:0]    HashCountRst = CntW'(7);

  // request from the sequencer to the probe engine
  typedef struct packed {
    logic                 start;
    logic                 adding;
    logic [CntW-1:0]      count;
    logic [HashW-1:0]     first_hash;
    logic [HashW-1:0]     second_hash;
    logic [ModW-1:0]      modulus;
    logic [PosW-1:0]      base_mod;
    logic [PosW-1:0]      stride_mod;
    logic [PosW-1:0]      wrap_mod;
  } probe_req_t;

  // status back from the probe engine
  typedef struct packed {
    logic clear_busy;
    logic done;
    logic present;
  } probe_sts_t;

  // residues from the reduction unit
  typedef struct packed {
    logic                 done;
    logic [PosW-1:0]      base_mod;
    logic [PosW-1:0]      stride_mod;
    logic [PosW-1:0]      wrap_mod;
  } red_res_t;

  // modulus actually used: zero acts as one, large values clamp
  function automatic logic [ModW-1:0] eff_modulus(input logic [ModW-1:0] size_cfg);
    logic [ModW-1:0] m;
    begin
      if (size_cfg == '0) begin
        m = ModW'(1);
      end else if (size_cfg > ModW'(MaxBits)) begin
        m = ModW'(MaxBits);
      end else begin
        m = size_cfg;
      end
      return m;
    end
  endfunction

  function automatic logic [CntW-1:0] eff_probes(input logic [CntW-1:0] nprobe_cfg);
    logic [CntW-1:0] p;
    begin
      if (nprobe_cfg > CntW'(MaxProbes)) begin
        p = CntW'(MaxProbes);
      end else begin
        p = nprobe_cfg;
      end
      return p;
    end
  endfunction

  // one restoring step: (2r + bit) mod m, with r < m
  function automatic logic [PosW-1:0] mod_step(input logic [PosW-1:0] r,
                                               input logic            b,
                                               input logic [ModW-1:0] m);
    logic [ModW-1:0] t;
    logic [ModW-1:0] d;
    begin
      t = {r, b};
      d = t - m;
      if (t >= m) begin
        return d[PosW-1:0];
      end else begin
        return t[PosW-1:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bfdh_if.sv */
// request and result channel interfaces
`default_nettype none

interface bfdh_in_if import bfdh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [HashW-1:0] first_hash;
  logic [HashW-1:0] second_hash;

  modport source (output valid, action, first_hash, second_hash, input ready);
  modport sink   (input valid, action, first_hash, second_hash, output ready);
endinterface

interface bfdh_out_if ();
  logic valid;
  logic ready;
  logic present;

  modport source (output valid, present, input ready);
  modport sink   (input valid, present, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bloom_filter_double_hash.sv */
// top level of the bloom filter probe engine with double hashing
//
//  channel   dir  handshake         payload
//  in_ch     in   valid / ready     action, first_hash[63:0], second_hash[63:0]
//  out_ch    out  valid / ready     present
//  cfg_*     in   cfg_we            cfg_index (0 filter size, 1 probe count), cfg_wdata[16:0]
//
// from accept to result a request folds its residues, then does one store read per probe
//   (probes clamp at 16), pipelined with forwarding
// a zero probe count answers present without touching the store
// after reset a clearing pass zeroes the 1024-word store, no request taken
// one request in flight; the next is taken while a finished result waits on out_ch
`default_nettype none

module bloom_filter_double_hash import bfdh_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  bfdh_in_if.sink                  in_ch,
  bfdh_out_if.source               out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  // sequencer states
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StReduce = 2'd1;
  localparam logic [1:0] StProbe  = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;

  // configuration registers
  logic [ModW-1:0]  size_cfg_r;
  logic [CntW-1:0]  nprobe_cfg_r;

  // request held for the probe engine
  logic             adding_r;
  logic [HashW-1:0] first_hash_r;
  logic [HashW-1:0] second_hash_r;
  logic [ModW-1:0]  modulus_r;
  logic [CntW-1:0]  probes_r;
  logic             result_r;

  // output register
  logic             out_valid_r;
  logic             out_present_r;

  logic             accept;
  logic             out_load;
  logic [ModW-1:0]  modulus_cur;
  logic [CntW-1:0]  probes_cur;
  red_res_t         red;
  probe_req_t       preq;
  probe_sts_t       psts;

  assign modulus_cur = eff_modulus(size_cfg_r);
  assign probes_cur  = eff_probes(nprobe_cfg_r);

  // new request only while idle and the store is not being cleared
  assign in_ch.ready = (state_r == StIdle) && !psts.clear_busy;
  assign accept      = in_ch.valid && in_ch.ready;
  // result moves into the output slot once it is free or being drained
  assign out_load    = (state_r == StFinish) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      StIdle: begin
        if (accept) begin
          state_nxt = (probes_cur == '0) ? StFinish : StReduce;
        end
      end
      StReduce: begin
        if (red.done) begin
          state_nxt = StProbe;
        end
      end
      StProbe: begin
        if (psts.done) begin
          state_nxt = StFinish;
        end
      end
      StFinish: begin
        if (out_load) begin
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= StIdle;
      size_cfg_r   <= BitCountRst;
      nprobe_cfg_r <= HashCountRst;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgBitCount:  size_cfg_r   <= cfg_wdata[ModW-1:0];
          CfgHashCount: nprobe_cfg_r <= cfg_wdata[CntW-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      adding_r      <= in_ch.action;
      first_hash_r  <= in_ch.first_hash;
      second_hash_r <= in_ch.second_hash;
      modulus_r     <= modulus_cur;
      probes_r      <= probes_cur;
      // no probes: answer present straight away
      result_r      <= 1'b1;
    end else if (state_r == StProbe && psts.done) begin
      result_r      <= psts.present;
    end
    if (out_load) begin
      out_present_r <= result_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.present = out_present_r;

  // residues of a, b and 2^64, folded 8 bits a cycle
  bfdh_modred u_modred (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (accept && probes_cur != '0),
    .first_hash  (in_ch.first_hash),
    .second_hash (in_ch.second_hash),
    .modulus     (modulus_cur),
    .res         (red)
  );

  always_comb begin
    preq.start       = (state_r == StReduce) && red.done;
    preq.adding      = adding_r;
    preq.count       = probes_r;
    preq.first_hash  = first_hash_r;
    preq.second_hash = second_hash_r;
    preq.modulus     = modulus_r;
    preq.base_mod    = red.base_mod;
    preq.stride_mod  = red.stride_mod;
    preq.wrap_mod    = red.wrap_mod;
  end

  bfdh_probe u_probe (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (preq),
    .sts   (psts)
  );

`ifndef SYNTHESIS
  a_red_done_in_reduce : assert property (@(posedge clk) disable iff (!rst_n)
    red.done |-> (state_r == StReduce))
    else $error("residues ready outside the reduce phase");

  a_probe_done_in_probe : assert property (@(posedge clk) disable iff (!rst_n)
    psts.done |-> (state_r == StProbe))
    else $error("probe engine finished outside the probe phase");

  a_add_answers_present : assert property (@(posedge clk) disable iff (!rst_n)
    (psts.done && adding_r) |-> psts.present)
    else $error("add answered not present");

  a_leave_idle_on_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StIdle && state_nxt != StIdle) |-> accept)
    else $error("sequencer left idle without a request");

  a_no_work_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    psts.clear_busy |-> (state_r == StIdle))
    else $error("request in flight during the clearing pass");
`endif

endmodule

`default_nettype wire

/* hw/rtl/bfdh_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none

module bfdh_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];

  // read during write to the same address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bfdh_modred.sv */
// reduction of both hashes and of 2^64 modulo the filter size
`default_nettype none

module bfdh_modred import bfdh_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [HashW-1:0]  first_hash,
  input  wire logic [HashW-1:0]  second_hash,
  input  wire logic [ModW-1:0]   modulus,
  output red_res_t               res
);

  logic                busy_r;
  logic                done_r;
  logic [RedCntW-1:0]  cnt_r;
  logic [ModW-1:0]     m_r;
  logic [HashW-1:0]    sa_r;
  logic [HashW-1:0]    sb_r;
  logic [PosW-1:0]     ra_r;
  logic [PosW-1:0]     rb_r;
  logic [PosW-1:0]     rt_r;
  logic [PosW-1:0]     ra_nxt;
  logic [PosW-1:0]     rb_nxt;
  logic [PosW-1:0]     rt_nxt;

  // fold RedBits bits msb first into each residue
  always_comb begin
    ra_nxt = ra_r;
    rb_nxt = rb_r;
    rt_nxt = rt_r;
    for (int k = 0; k < RedBits; k++) begin
      ra_nxt = mod_step(ra_nxt, sa_r[HashW-1-k], m_r);
      rb_nxt = mod_step(rb_nxt, sb_r[HashW-1-k], m_r);
      rt_nxt = mod_step(rt_nxt, 1'b0, m_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == RedCntW'(RedCycles - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + RedCntW'(1);
        if (cnt_r == RedCntW'(RedCycles - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_r  <= modulus;
      sa_r <= first_hash;
      sb_r <= second_hash;
      ra_r <= '0;
      rb_r <= '0;
      // 1 mod m, then 64 zero bits give 2^64 mod m
      rt_r <= (modulus == ModW'(1)) ? '0 : PosW'(1);
    end else if (busy_r) begin
      sa_r <= sa_r << RedBits;
      sb_r <= sb_r << RedBits;
      ra_r <= ra_nxt;
      rb_r <= rb_nxt;
      rt_r <= rt_nxt;
    end
  end

  assign res.done       = done_r;
  assign res.base_mod   = ra_r;
  assign res.stride_mod = rb_r;
  assign res.wrap_mod   = rt_r;

endmodule

`default_nettype wire

/* hw/rtl/bfdh_probe.sv */
// probe engine: position stepping, bit store read-modify-write, clearing pass
`default_nettype none

module bfdh_probe import bfdh_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  probe_req_t req,
  output probe_sts_t sts
);

  // clearing pass
  logic                clr_busy_r;
  logic [AddrW-1:0]    clr_addr_r;

  // issue stage
  logic                iss_busy_r;
  logic                adding_r;
  logic [CntW-1:0]     left_r;
  logic [PosW-1:0]     x_r;
  logic [PosW-1:0]     x_nxt;
  logic [PosW-1:0]     s_r;
  logic [PosW-1:0]     t_r;
  logic [ModW-1:0]     m_r;
  logic [HashW-1:0]    h_r;
  logic [HashW-1:0]    b_r;
  logic [HashW-1:0]    h_nxt;
  logic                carry;

  // data stage
  logic                s2_valid_r;
  logic                s2_last_r;
  logic [AddrW-1:0]    s2_addr_r;
  logic [BitIdxW-1:0]  s2_bit_r;
  logic                present_r;

  // forwarding of the word written in the previous cycle
  logic                fw_valid_r;
  logic [AddrW-1:0]    fw_addr_r;
  logic [WordBits-1:0] fw_data_r;

  logic [WordBits-1:0] rdata;
  logic [WordBits-1:0] word;
  logic [WordBits-1:0] word_set;
  logic                hit;
  logic                s2_write;
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [WordBits-1:0] ram_wdata;

  // next position: x + (b mod m), minus (2^64 mod m) when the hash wraps
  always_comb begin
    logic [ModW-1:0] y;
    y = {1'b0, x_r} + {1'b0, s_r};
    {carry, h_nxt} = {1'b0, h_r} + {1'b0, b_r};
    if (y >= m_r) begin
      y = y - m_r;
    end
    if (carry) begin
      if (y >= {1'b0, t_r}) begin
        y = y - {1'b0, t_r};
      end else begin
        y = y + m_r - {1'b0, t_r};
      end
    end
    x_nxt = y[PosW-1:0];
  end

  always_comb begin
    word     = (fw_valid_r && fw_addr_r == s2_addr_r) ? fw_data_r : rdata;
    hit      = word[s2_bit_r];
    word_set = word | (WordBits'(1) << s2_bit_r);
    s2_write = s2_valid_r && adding_r;
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s2_write;
      ram_waddr = s2_addr_r;
      ram_wdata = word_set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      iss_busy_r <= 1'b0;
      s2_valid_r <= 1'b0;
      fw_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AddrW'(1);
        if (clr_addr_r == AddrW'(StoreWords - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (req.start) begin
        iss_busy_r <= 1'b1;
      end else if (iss_busy_r && left_r == CntW'(1)) begin
        iss_busy_r <= 1'b0;
      end
      s2_valid_r <= iss_busy_r;
      fw_valid_r <= s2_write;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      adding_r  <= req.adding;
      left_r    <= req.count;
      x_r       <= req.base_mod;
      s_r       <= req.stride_mod;
      t_r       <= req.wrap_mod;
      m_r       <= req.modulus;
      h_r       <= req.first_hash;
      b_r       <= req.second_hash;
      present_r <= 1'b1;
    end else begin
      if (iss_busy_r) begin
        left_r <= left_r - CntW'(1);
        x_r    <= x_nxt;
        h_r    <= h_nxt;
      end
      if (s2_valid_r && !adding_r) begin
        present_r <= present_r & hit;
      end
    end
    s2_last_r <= (left_r == CntW'(1));
    s2_addr_r <= x_r[PosW-1:BitIdxW];
    s2_bit_r  <= x_r[BitIdxW-1:0];
    fw_addr_r <= s2_addr_r;
    fw_data_r <= word_set;
  end

  bfdh_ram #(
    .Width (WordBits),
    .Depth (StoreWords)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (iss_busy_r),
    .raddr (x_r[PosW-1:BitIdxW]),
    .rdata (rdata)
  );

  assign sts.clear_busy = clr_busy_r;
  assign sts.done       = s2_valid_r && s2_last_r;
  assign sts.present    = adding_r | (present_r & hit);

endmodule

`default_nettype wire
